// ===== rtl/core/pedwd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedwd_pkg
// Shared types and codes of the priority event dispatcher.
// ----------------------------------------------------------------------------
package pedwd_pkg;

  localparam int EV_W   = 16;
  localparam int DATA_W = 32;
  localparam int ITEM_W = EV_W + DATA_W;

  typedef struct packed {
    logic [EV_W-1:0]   ev;
    logic [DATA_W-1:0] data;
  } item_t;

  localparam logic [1:0] CMD_POST     = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_DISPATCH = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_ENABLED = 3'd1;
  localparam logic [2:0] ST_FIFO_FULL   = 3'd2;
  localparam logic [2:0] ST_DELAY_FULL  = 3'd3;
  localparam logic [2:0] ST_EMPTY       = 3'd4;

endpackage

// ===== rtl/core/pedwd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedwd_ram
// Item memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pedwd_ram
  import pedwd_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  item_t         wdata,
  input  logic [AW-1:0] raddr,
  output item_t         rdata
);

  item_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/priority_event_dispatcher_with_delays_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_event_dispatcher_with_delays_unit
// Per-slot event FIFOs with a delay list and priority dispatch.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Exactly one
// result per transaction appears on the result ports for one cycle with done
// high; the receiver cannot stall, so sample it then. Post and unused
// commands answer in the cycle after acceptance. Dispatch answers after the
// FIFO memory read and the result registers, or in the cycle after acceptance
// when nothing is pending. Tick visits one delay entry per cycle through the
// delay payload memory; done follows the last visit. busy stays low in the
// cycle done is shown. posted_count, failed_count and waiting_delayed show
// the live counters and are valid with done. The user writes task_enable
// through cfg_wr_en / cfg_wr_data only while idle; the block does not check.
// ----------------------------------------------------------------------------
module priority_event_dispatcher_with_delays_unit
  import pedwd_pkg::*;
#(
  parameter int PRIORITY_LEVELS  = 4,
  parameter int SLOTS_PER_LEVEL  = 4,
  parameter int DELAY_ENTRIES    = 8,
  parameter int EVENT_FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [3:0]  task_slot,
  input  logic [15:0] event_code,
  input  logic [31:0] data_word,
  input  logic [15:0] delay_ticks,
  output logic        done,
  output logic [2:0]  status,
  output logic [3:0]  out_task_slot,
  output logic [15:0] out_event,
  output logic [31:0] out_data,
  output logic [15:0] posted_count,
  output logic [15:0] failed_count,
  output logic [3:0]  waiting_delayed
);

  localparam int NUM_SLOTS = PRIORITY_LEVELS * SLOTS_PER_LEVEL;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PTR_W     = (EVENT_FIFO_DEPTH > 1) ? $clog2(EVENT_FIFO_DEPTH) : 1;
  localparam int FILL_W    = $clog2(EVENT_FIFO_DEPTH + 1);
  localparam int FDEPTH    = NUM_SLOTS * EVENT_FIFO_DEPTH;
  localparam int FA_W      = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
  localparam int DI_W      = (DELAY_ENTRIES > 1) ? $clog2(DELAY_ENTRIES) : 1;
  localparam int CNT_W     = $clog2(DELAY_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_DISP = 2'd2;

  logic [1:0]  state;
  logic [15:0] task_enable;

  // per-slot FIFO control
  logic [PTR_W-1:0]  rd_ptr [NUM_SLOTS];
  logic [FILL_W-1:0] fill   [NUM_SLOTS];

  // delay list timing; payload lives in memory
  logic        d_use   [DELAY_ENTRIES];
  logic [3:0]  d_slot  [DELAY_ENTRIES];
  logic [15:0] d_ticks [DELAY_ENTRIES];
  logic [CNT_W-1:0] d_count;
  logic [DI_W-1:0]  idx;

  logic [15:0] post_total;
  logic [15:0] post_fail;
  logic [3:0]  disp_slot;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  function automatic logic slot_en(input logic [3:0] s, input logic [15:0] en);
    return (int'(s) < NUM_SLOTS) && en[s];
  endfunction

  // dispatch search: lowest non-empty slot
  logic             any_pend;
  logic [SLOT_W-1:0] pend_slot;
  always_comb begin
    any_pend  = 1'b0;
    pend_slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (fill[i] != '0) begin
        any_pend  = 1'b1;
        pend_slot = SLOT_W'(i);
      end
    end
  end

  // lowest free delay entry
  logic            any_free;
  logic [DI_W-1:0] free_idx;
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = DELAY_ENTRIES - 1; i >= 0; i--) begin
      if (!d_use[i]) begin
        any_free = 1'b1;
        free_idx = DI_W'(i);
      end
    end
  end

  // tick view of the current entry
  item_t       dly_rdata;
  logic [15:0] t_next;
  assign t_next = (d_ticks[idx] != 16'd0) ? d_ticks[idx] - 16'd1 : 16'd0;

  // shared FIFO push path (immediate post or tick handover)
  logic              push_req;
  logic [3:0]        push_slot4;
  item_t             push_item;
  logic [SLOT_W-1:0] ps;
  logic              push_full;
  logic [PTR_W:0]    pos_sum;
  logic [PTR_W-1:0]  pos;
  logic              fifo_we;
  logic [FA_W-1:0]   fifo_waddr;
  logic [FA_W-1:0]   fifo_raddr;
  item_t             fifo_rdata;

  always_comb begin
    push_req   = 1'b0;
    push_slot4 = task_slot;
    push_item  = '{ev: event_code, data: data_word};
    if (state == S_IDLE) begin
      push_req = accept && (command == CMD_POST) && slot_en(task_slot, task_enable)
                 && (delay_ticks == 16'd0);
    end else if (state == S_TICK) begin
      push_slot4 = d_slot[idx];
      push_item  = dly_rdata;
      push_req   = d_use[idx] && (t_next == 16'd0) && slot_en(d_slot[idx], task_enable);
    end
    ps        = SLOT_W'(push_slot4);
    push_full = (fill[ps] == FILL_W'(EVENT_FIFO_DEPTH));
    pos_sum   = (PTR_W+1)'(rd_ptr[ps]) + (PTR_W+1)'(fill[ps]);
    if (pos_sum >= (PTR_W+1)'(EVENT_FIFO_DEPTH)) begin
      pos_sum = pos_sum - (PTR_W+1)'(EVENT_FIFO_DEPTH);
    end
    pos        = pos_sum[PTR_W-1:0];
    fifo_we    = push_req && !push_full;
    fifo_waddr = FA_W'(FA_W'(ps) * FA_W'(EVENT_FIFO_DEPTH) + FA_W'(pos));
    fifo_raddr = FA_W'(FA_W'(pend_slot) * FA_W'(EVENT_FIFO_DEPTH)
                       + FA_W'(rd_ptr[pend_slot]));
  end

  pedwd_ram #(.DEPTH(FDEPTH), .AW(FA_W)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (push_item),
    .raddr (fifo_raddr),
    .rdata (fifo_rdata)
  );

  // delay payload memory; the tick reads one entry ahead of the one it handles
  logic            dly_we;
  logic [DI_W-1:0] dly_raddr;
  assign dly_we    = accept && (command == CMD_POST) && slot_en(task_slot, task_enable)
                     && (delay_ticks != 16'd0) && any_free;
  assign dly_raddr = (state == S_IDLE) ? '0 : DI_W'(idx + DI_W'(1));

  pedwd_ram #(.DEPTH(DELAY_ENTRIES), .AW(DI_W)) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (free_idx),
    .wdata ('{ev: event_code, data: data_word}),
    .raddr (dly_raddr),
    .rdata (dly_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      task_enable <= '0;
      done        <= 1'b0;
      d_count     <= '0;
      idx         <= '0;
      post_total  <= '0;
      post_fail   <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        rd_ptr[i] <= '0;
        fill[i]   <= '0;
      end
      for (int i = 0; i < DELAY_ENTRIES; i++) begin
        d_use[i]   <= 1'b0;
        d_slot[i]  <= '0;
        d_ticks[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_wr_en) begin
        task_enable <= cfg_wr_data;
      end
      if (push_req) begin
        post_total <= post_total + 16'd1;
        if (push_full) begin
          post_fail <= post_fail + 16'd1;
        end else begin
          fill[ps] <= fill[ps] + FILL_W'(1);
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            status        <= ST_OK;
            out_task_slot <= '0;
            out_event     <= '0;
            out_data      <= '0;
            unique case (command)
              CMD_POST: begin
                done <= 1'b1;
                if (!slot_en(task_slot, task_enable)) begin
                  status <= ST_NOT_ENABLED;
                end else if (delay_ticks == 16'd0) begin
                  if (push_full) status <= ST_FIFO_FULL;
                end else if (any_free) begin
                  d_use[free_idx]   <= 1'b1;
                  d_slot[free_idx]  <= task_slot;
                  d_ticks[free_idx] <= delay_ticks;
                  d_count           <= d_count + CNT_W'(1);
                end else begin
                  status <= ST_DELAY_FULL;
                end
              end
              CMD_TICK: begin
                idx   <= '0;
                state <= S_TICK;
              end
              CMD_DISPATCH: begin
                if (any_pend) begin
                  disp_slot         <= 4'(pend_slot);
                  fill[pend_slot]   <= fill[pend_slot] - FILL_W'(1);
                  rd_ptr[pend_slot] <= (rd_ptr[pend_slot] == PTR_W'(EVENT_FIFO_DEPTH - 1))
                                       ? '0 : rd_ptr[pend_slot] + PTR_W'(1);
                  state             <= S_DISP;
                end else begin
                  status <= ST_EMPTY;
                  done   <= 1'b1;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_TICK: begin
          if (d_use[idx]) begin
            d_ticks[idx] <= t_next;
            if (push_req && !push_full) begin
              d_use[idx]  <= 1'b0;
              d_slot[idx] <= '0;
              d_count     <= d_count - CNT_W'(1);
            end
          end
          if (idx == DI_W'(DELAY_ENTRIES - 1)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx <= idx + DI_W'(1);
          end
        end
        S_DISP: begin
          out_task_slot <= disp_slot;
          out_event     <= fifo_rdata.ev;
          out_data      <= fifo_rdata.data;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign posted_count    = post_total;
  assign failed_count    = post_fail;
  assign waiting_delayed = 4'(d_count);

endmodule
